// ----- hdl/fqd_pkg.sv -----
`default_nettype none

package fqd_pkg;

    // Fixed widths of the request and result fields on the ports.
    localparam int HANDLE_IO_W = 32;
    localparam int LEN_W       = 5;
    localparam int FUNC_W      = 2;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;
    localparam int M_TUSER_W   = 2;

    // Operation codes carried on s_tuser.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQ  = 2'd0,
        FUNC_DEQ  = 2'd1,
        FUNC_DEL  = 2'd2,
        FUNC_DUMP = 2'd3
    } func_t;

    // Strobes from the sequencer to the entry store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage : fqd_pkg

`default_nettype wire

// ----- hdl/fqd_store.sv -----
`default_nettype none

module fqd_store import fqd_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int SW    = 32,
    parameter int AW    = 4
) (
    input  wire logic          aclk,
    input  wire mem_ctl_t      ctl,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [SW-1:0] wr_data,
    input  wire logic [AW-1:0] rd_addr,
    input  wire logic [SW-1:0] key,
    output logic      [SW-1:0] rd_data,
    output logic               match
);

    logic [SW-1:0] mem [DEPTH];
    logic [SW-1:0] rd_data_reg;

    // One write port and one registered read port. The read data holds
    // while no read is issued, so a stalled consumer can wait on it.
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

    // Shared compare unit used by the delete search.
    assign match = (rd_data_reg == key);

endmodule : fqd_store

`default_nettype wire

// ----- hdl/fifo_queue_with_delete_unit.sv -----
`default_nettype none

// Channel  Direction  Handshake          Payload
// request  in         s_tvalid/s_tready  s_tuser = func, s_tdata = item_handle
// result   out        m_tvalid/m_tready  m_tuser = status, item_valid;
//                                        m_tdata = out_handle, length; m_tlast = last
//
// A request is taken only while the sequencer is idle. Delete reads one entry
// per cycle through the single store read port and the shared comparator,
// then moves each later entry down one slot per cycle. Dump emits one entry
// per cycle while the result channel is not stalled.
// Reset clears the head, the count and the sequencer; the store is not cleared.
// A stalled result channel stops the sequencer only where a result is loaded.

module fifo_queue_with_delete_unit import fqd_pkg::*; #(
    parameter int DEPTH        = 16,
    parameter int HANDLE_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] item_handle
    input  wire logic [FUNC_W-1:0]     s_tuser,   // [1:0] func
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [31:0] out_handle, [36:32] length, rest 0
    output logic [M_TUSER_W-1:0]       m_tuser,   // [0] status, [1] item_valid
    output logic                       m_tlast    // last
);

    // Stored handles never need more bits than the handle field carries.
    localparam int SW = (HANDLE_WIDTH < HANDLE_IO_W) ? HANDLE_WIDTH : HANDLE_IO_W;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DEQ,
        ST_SEARCH,
        ST_SHIFT,
        ST_DUMP,
        ST_RESP
    } state_t;

    state_t        state_reg, state_next;
    func_t         op_reg, op_next;
    logic [SW-1:0] key_reg, key_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic          res_status_reg, res_status_next;
    logic          res_valid_reg, res_valid_next;
    logic [SW-1:0] res_handle_reg, res_handle_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic          m_status_reg, m_status_next;
    logic          m_item_valid_reg, m_item_valid_next;
    logic [SW-1:0] m_handle_reg, m_handle_next;
    logic [LEN_W-1:0] m_length_reg, m_length_next;
    logic          m_last_reg, m_last_next;

    mem_ctl_t      mem_ctl;
    logic [AW-1:0] rd_pos, wr_pos, rd_addr, wr_addr;
    logic [SW-1:0] rd_data;
    logic          match;
    logic          out_free;
    logic [CW-1:0] pos_inc;
    logic          more;

    // Slot of a queue position: head plus position, folded once at DEPTH.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [AW-1:0] pos);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= DEPTH_S) begin
            sum = sum - DEPTH_S;
        end
        return sum[AW-1:0];
    endfunction

    assign out_free = !m_tvalid_reg || m_tready;
    assign pos_inc  = CW'(pos_reg) + CW'(1);
    assign more     = (pos_inc < count_reg);

    // The read side always looks at the head in the decode cycle and at the
    // next position afterwards. The write side appends at the tail in the
    // decode cycle and, during a delete, writes each read entry one slot below its own.
    assign rd_pos  = (state_reg == ST_DECODE) ? '0 : pos_inc[AW-1:0];
    assign wr_pos  = (state_reg == ST_DECODE) ? count_reg[AW-1:0] : (pos_reg - AW'(1));
    assign rd_addr = slot_of(head_reg, rd_pos);
    assign wr_addr = slot_of(head_reg, wr_pos);

    fqd_store #(
        .DEPTH (DEPTH),
        .SW    (SW),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data ((state_reg == ST_DECODE) ? key_reg : rd_data),
        .rd_addr (rd_addr),
        .key     (key_reg),
        .rd_data (rd_data),
        .match   (match)
    );

    always_comb begin
        state_next        = state_reg;
        op_next           = op_reg;
        key_next          = key_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        pos_next          = pos_reg;
        res_status_next   = res_status_reg;
        res_valid_next    = res_valid_reg;
        res_handle_next   = res_handle_reg;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_status_next     = m_status_reg;
        m_item_valid_next = m_item_valid_reg;
        m_handle_next     = m_handle_reg;
        m_length_next     = m_length_reg;
        m_last_next       = m_last_reg;
        mem_ctl           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = func_t'(s_tuser);
                    key_next   = s_tdata[SW-1:0];
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                res_status_next = 1'b1;
                res_valid_next  = 1'b0;
                res_handle_next = '0;
                pos_next        = '0;
                state_next      = ST_RESP;
                unique case (op_reg)
                    FUNC_ENQ: begin
                        if (key_reg != '0 && count_reg != FULL_CNT) begin
                            mem_ctl.wr_en   = 1'b1;
                            count_next      = count_reg + CW'(1);
                            res_status_next = 1'b0;
                        end
                    end
                    FUNC_DEQ: begin
                        if (count_reg != '0) begin
                            mem_ctl.rd_en = 1'b1;
                            state_next    = ST_DEQ;
                        end
                    end
                    FUNC_DEL: begin
                        if (key_reg != '0 && count_reg != '0) begin
                            mem_ctl.rd_en = 1'b1;
                            state_next    = ST_SEARCH;
                        end
                    end
                    FUNC_DUMP: begin
                        // An empty queue still answers with one result.
                        res_status_next = 1'b0;
                        if (count_reg != '0) begin
                            mem_ctl.rd_en = 1'b1;
                            state_next    = ST_DUMP;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DEQ: begin
                res_status_next = 1'b0;
                res_valid_next  = 1'b1;
                res_handle_next = rd_data;
                head_next       = (head_reg == LAST_SLOT) ? '0 : head_reg + AW'(1);
                count_next      = count_reg - CW'(1);
                state_next      = ST_RESP;
            end
            ST_SEARCH: begin
                if (match) begin
                    res_status_next = 1'b0;
                    if (more) begin
                        mem_ctl.rd_en = 1'b1;
                        pos_next      = pos_inc[AW-1:0];
                        state_next    = ST_SHIFT;
                    end else begin
                        count_next = count_reg - CW'(1);
                        state_next = ST_RESP;
                    end
                end else if (more) begin
                    mem_ctl.rd_en = 1'b1;
                    pos_next      = pos_inc[AW-1:0];
                end else begin
                    state_next = ST_RESP;
                end
            end
            ST_SHIFT: begin
                // The entry at pos moves down into the slot before it.
                mem_ctl.wr_en = 1'b1;
                if (more) begin
                    mem_ctl.rd_en = 1'b1;
                    pos_next      = pos_inc[AW-1:0];
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_RESP;
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    m_tvalid_next     = 1'b1;
                    m_status_next     = 1'b0;
                    m_item_valid_next = 1'b1;
                    m_handle_next     = rd_data;
                    m_length_next     = LEN_W'(count_reg);
                    m_last_next       = !more;
                    if (more) begin
                        mem_ctl.rd_en = 1'b1;
                        pos_next      = pos_inc[AW-1:0];
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_tvalid_next     = 1'b1;
                    m_status_next     = res_status_reg;
                    m_item_valid_next = res_valid_reg;
                    m_handle_next     = res_handle_reg;
                    m_length_next     = LEN_W'(count_reg);
                    m_last_next       = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg           <= op_next;
        key_reg          <= key_next;
        pos_reg          <= pos_next;
        res_status_reg   <= res_status_next;
        res_valid_reg    <= res_valid_next;
        res_handle_reg   <= res_handle_next;
        m_status_reg     <= m_status_next;
        m_item_valid_reg <= m_item_valid_next;
        m_handle_reg     <= m_handle_next;
        m_length_reg     <= m_length_next;
        m_last_reg       <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - LEN_W - HANDLE_IO_W)'(0), m_length_reg,
                       HANDLE_IO_W'(m_handle_reg)};
    assign m_tuser  = {m_item_valid_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

    // The entry count never passes the store depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("entry count above depth");

    // The sequencer is busy in the cycle after a request is taken, so the next one waits.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // A handle shown on the result side is always a stored, nonzero handle.
    a_handle_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[HANDLE_IO_W-1:0] != '0)
        else $error("zero handle reported as valid");

    // An error result carries no handle and closes its request.
    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tuser[1] && m_tlast)
        else $error("malformed error result");

endmodule : fifo_queue_with_delete_unit

`default_nettype wire
